>>> rtl/core/b64enc_pkg.sv
// ----------------------------------------------------------------------------
// b64enc_pkg
// Shared types, constants and the alphabet lookup for the streaming base64
// encoder.
// ----------------------------------------------------------------------------
package b64enc_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [6:0] PadIdx = 7'd64;

  localparam logic [6:0] SymUpperA = 7'h41;
  localparam logic [6:0] SymUpperZ = 7'h5A;
  localparam logic [6:0] SymLowerA = 7'h61;
  localparam logic [6:0] SymLowerZ = 7'h7A;
  localparam logic [6:0] SymDigit0 = 7'h30;
  localparam logic [6:0] SymDigit9 = 7'h39;
  localparam logic [6:0] SymPlus   = 7'h2B;
  localparam logic [6:0] SymSlash  = 7'h2F;
  localparam logic [6:0] SymPad    = 7'h3D;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_req_t;

  typedef struct packed {
    logic [6:0] symbol;
    logic       last_symbol;
  } out_req_t;

  // One queued job: up to four alphabet indexes, the index of the final one
  // and whether that final one closes the message.
  typedef struct packed {
    logic [3:0][6:0] code;
    logic [1:0]      last_idx;
    logic            last;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  function automatic logic [6:0] to_ascii(input logic [6:0] idx);
    logic [6:0] sym;
    if (idx < 7'd26) begin
      sym = SymUpperA + idx;
    end else if (idx < 7'd52) begin
      sym = idx + 7'd71;
    end else if (idx < 7'd62) begin
      sym = idx - 7'd4;
    end else if (idx == 7'd62) begin
      sym = SymPlus;
    end else if (idx == 7'd63) begin
      sym = SymSlash;
    end else begin
      sym = SymPad;
    end
    return sym;
  endfunction

endpackage

>>> rtl/core/b64enc_front.sv
// ----------------------------------------------------------------------------
// b64enc_front
// Accepts raw bytes, tracks the position within the three-byte group and the
// leftover bits, and turns each byte into one queued job of alphabet indexes.
// ----------------------------------------------------------------------------
module b64enc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  b64enc_pkg::in_req_t in_req_i,
  input  logic              q_full_i,
  output logic              push_o,
  output b64enc_pkg::cmd_t  cmd_o
);
  import b64enc_pkg::*;

  logic [1:0] phase_q, phase_d;
  logic [5:0] carry_q, carry_d;
  logic [5:0] next_carry;
  logic [7:0] b;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign b          = in_req_i.data_byte;

  always_comb begin
    cmd_o      = '0;
    next_carry = '0;
    phase_d    = phase_q;
    carry_d    = carry_q;
    case (phase_q)
      2'd1: begin
        cmd_o.code[0] = {1'b0, carry_q | {2'b00, b[7:4]}};
        next_carry    = {b[3:0], 2'b00};
        if (in_req_i.end_of_message) begin
          cmd_o.code[1]  = {1'b0, next_carry};
          cmd_o.code[2]  = PadIdx;
          cmd_o.last_idx = 2'd2;
        end
        phase_d = 2'd2;
        carry_d = next_carry;
      end
      2'd2: begin
        cmd_o.code[0]  = {1'b0, carry_q | {4'b0000, b[7:6]}};
        cmd_o.code[1]  = {1'b0, b[5:0]};
        cmd_o.last_idx = 2'd1;
        phase_d        = 2'd0;
        carry_d        = '0;
      end
      default: begin
        cmd_o.code[0] = {1'b0, b[7:2]};
        next_carry    = {b[1:0], 4'b0000};
        if (in_req_i.end_of_message) begin
          cmd_o.code[1]  = {1'b0, next_carry};
          cmd_o.code[2]  = PadIdx;
          cmd_o.code[3]  = PadIdx;
          cmd_o.last_idx = 2'd3;
        end
        phase_d = 2'd1;
        carry_d = next_carry;
      end
    endcase
    cmd_o.last = in_req_i.end_of_message;
    if (in_req_i.end_of_message) begin
      phase_d = 2'd0;
      carry_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      carry_q <= '0;
    end else if (push_o) begin
      phase_q <= phase_d;
      carry_q <= carry_d;
    end
  end

endmodule

>>> rtl/core/b64enc_queue.sv
// ----------------------------------------------------------------------------
// b64enc_queue
// Short job queue between the byte front end and the character back end.
// ----------------------------------------------------------------------------
module b64enc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  b64enc_pkg::cmd_t   cmd_i,
  output logic               full_o,
  input  logic               pop_i,
  output b64enc_pkg::head_t  head_o
);
  import b64enc_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(QueueDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

>>> rtl/core/b64enc_back.sv
// ----------------------------------------------------------------------------
// b64enc_back
// Walks the head job one character per cycle while the output is not stalled,
// maps alphabet indexes to ASCII and holds each character in the output register
// until it is taken.
module b64enc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  b64enc_pkg::head_t   head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output b64enc_pkg::out_req_t out_req_o
);
  import b64enc_pkg::*;

  logic       out_valid_q, out_valid_d;
  out_req_t   out_q, out_d;
  logic [1:0] idx_q, idx_d;
  logic       can_load, load, at_end;

  assign can_load = !out_valid_q || !out_stall_i;
  assign load     = head_i.valid && can_load;
  assign at_end   = (idx_q == head_i.cmd.last_idx);
  assign pop_o    = load && at_end;

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    if (can_load) begin
      out_valid_d = head_i.valid;
    end
    if (load) begin
      out_d.symbol      = to_ascii(head_i.cmd.code[idx_q]);
      out_d.last_symbol = head_i.cmd.last && at_end;
      idx_d             = at_end ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

>>> rtl/core/base64_stream_encoder.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder with the standard alphabet and '=' padding.
//
//   Channel  Direction  Handshake             Request
//   in       input      in_valid_i/in_stall_o  data_byte, end_of_message
//   out      output     out_valid_o/out_stall_i symbol, last_symbol
//
// A byte is taken every cycle while the two-entry job queue has room.
// Characters leave at one per cycle from the output register while the
// output is not stalled; a byte yields one or two characters, three or four
// for a final byte that leaves a partial group, and four per three bytes.
// A byte's job enters the queue, then its first character the output register.
// Reset clears the group position, leftover bits, queue and output valid.
// A stalled output holds its character while the front keeps filling the queue.
// ----------------------------------------------------------------------------
module base64_stream_encoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  b64enc_pkg::in_req_t  in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output b64enc_pkg::out_req_t out_req_o
);
  import b64enc_pkg::*;

  logic  q_full;
  logic  push;
  logic  pop;
  cmd_t  cmd;
  head_t head;

  b64enc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  b64enc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .full_o (q_full),
    .pop_i  (pop),
    .head_o (head)
  );

  b64enc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule

>>> rtl/core/b64enc_checker.sv
// ----------------------------------------------------------------------------
// b64enc_checker
// Port-level checks on the streaming base64 encoder.
// ----------------------------------------------------------------------------
module b64enc_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input b64enc_pkg::out_req_t out_req_o
);
  import b64enc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_req_o))
    else $error("stalled output request changed");

  a_legal_symbol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_req_o.symbol >= SymUpperA && out_req_o.symbol <= SymUpperZ) ||
      (out_req_o.symbol >= SymLowerA && out_req_o.symbol <= SymLowerZ) ||
      (out_req_o.symbol >= SymDigit0 && out_req_o.symbol <= SymDigit9) ||
      out_req_o.symbol == SymPlus || out_req_o.symbol == SymSlash ||
      out_req_o.symbol == SymPad)
    else $error("symbol outside the base64 alphabet");

  a_pad_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_req_o.symbol == SymPad &&
      !out_req_o.last_symbol
    |=> out_valid_o && out_req_o.symbol == SymPad && out_req_o.last_symbol)
    else $error("first pad not followed at once by the final pad");

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !out_valid_o |-> !in_stall_o)
    else $error("input stalled while the output is idle");

  a_reset_clear: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind base64_stream_encoder b64enc_checker u_b64enc_checker (.*);

>>> verif/tb_b64_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_b64_pkg
// Scoreboard for the streaming base64 encoder. It keeps its own copy of the
// group position and leftover bits, expands every accepted byte into the
// characters it should produce, and checks each delivered character in order.
// ----------------------------------------------------------------------------
package tb_b64_pkg;

  import b64enc_pkg::*;

  localparam string Base64Chars =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/=";

  class base64_checker;

    logic [1:0] group_pos;
    logic [5:0] leftover;
    out_req_t   expected_symbols[$];
    int         errors;
    int         bytes_seen;
    int         messages_seen;
    int         symbols_checked;

    function new();
      group_pos       = 2'd0;
      leftover        = 6'd0;
      errors          = 0;
      bytes_seen      = 0;
      messages_seen   = 0;
      symbols_checked = 0;
    endfunction

    function void push_code(logic [6:0] code, logic last);
      out_req_t sym;
      sym.symbol      = 7'(Base64Chars[code]);
      sym.last_symbol = last;
      expected_symbols.push_back(sym);
    endfunction

    function void note_byte(in_req_t req);
      logic [7:0] b;
      logic       eom;
      b   = req.data_byte;
      eom = req.end_of_message;
      bytes_seen++;
      case (group_pos)
        2'd1: begin
          push_code({1'b0, leftover | {2'b00, b[7:4]}}, 1'b0);
          leftover = {b[3:0], 2'b00};
          if (eom) begin
            push_code({1'b0, leftover}, 1'b0);
            push_code(PadIdx, 1'b1);
          end
          group_pos = 2'd2;
        end
        2'd2: begin
          push_code({1'b0, leftover | {4'b0000, b[7:6]}}, 1'b0);
          push_code({1'b0, b[5:0]}, eom);
          leftover  = 6'd0;
          group_pos = 2'd0;
        end
        default: begin
          push_code({1'b0, b[7:2]}, 1'b0);
          leftover = {b[1:0], 4'b0000};
          if (eom) begin
            push_code({1'b0, leftover}, 1'b0);
            push_code(PadIdx, 1'b0);
            push_code(PadIdx, 1'b1);
          end
          group_pos = 2'd1;
        end
      endcase
      if (eom) begin
        group_pos = 2'd0;
        leftover  = 6'd0;
        messages_seen++;
      end
    endfunction

    function void check_symbol(out_req_t got);
      out_req_t want;
      if (expected_symbols.size() == 0) begin
        $error("unexpected character: symbol %02h last_symbol %0b",
               got.symbol, got.last_symbol);
        errors++;
        return;
      end
      want = expected_symbols.pop_front();
      symbols_checked++;
      if (got.symbol !== want.symbol) begin
        $error("symbol: expected %02h, actual %02h", want.symbol, got.symbol);
        errors++;
      end
      if (got.last_symbol !== want.last_symbol) begin
        $error("last_symbol: expected %0b, actual %0b",
               want.last_symbol, got.last_symbol);
        errors++;
      end
    endfunction

    function int pending();
      return expected_symbols.size();
    endfunction

    function void finish();
      if (expected_symbols.size() != 0) begin
        $error("%0d characters never delivered", expected_symbols.size());
        errors++;
      end
    endfunction

  endclass

endpackage

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for base64_stream_encoder. A directed set of short messages
// covers every group position at the end of a message, the byte extremes and
// the '+' and '/' characters; random messages follow. The sender works in
// bursts with gaps, the receiver stalls in changing patterns, and every
// character is checked against the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;

  import b64enc_pkg::*;
  import tb_b64_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int RandomBytes = 160;

  typedef enum int {
    StallNone,
    StallLight,
    StallHeavy,
    StallPeriodic
  } stall_mode_e;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid    = 1'b0;
  logic     in_stall;
  in_req_t  in_req      = '0;
  logic     out_valid;
  logic     out_stall   = 1'b0;
  out_req_t out_req;

  base64_checker sb = new();

  int          cycle_count = 0;
  int          burst_left  = 0;
  stall_mode_e stall_mode  = StallNone;
  int          mode_left   = 0;
  int          period_pos  = 0;

  base64_stream_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_req_o   (out_req)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid && !in_stall) begin
      sb.note_byte(in_req);
    end
    if (rst_ni && out_valid && !out_stall) begin
      sb.check_symbol(out_req);
    end
  end

  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      mode_left  = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    period_pos = (period_pos + 1) % 5;
    case (stall_mode)
      StallNone:  out_stall <= 1'b0;
      StallLight: out_stall <= ($urandom_range(0, 3) == 0);
      StallHeavy: out_stall <= ($urandom_range(0, 9) < 7);
      default:    out_stall <= (period_pos < 2);
    endcase
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("base64_stream_encoder verification failed");
    $finish;
  end

  task automatic send_byte(logic [7:0] b, logic eom);
    int      gap;
    in_req_t req;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req.data_byte      = b;
    req.end_of_message = eom;
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic send_message(logic [7:0] bytes[$]);
    foreach (bytes[i]) begin
      send_byte(bytes[i], i == bytes.size() - 1);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_message(int len);
    logic [7:0] bytes[$];
    repeat (len) begin
      case ($urandom_range(0, 9))
        0:       bytes.push_back(8'h00);
        1:       bytes.push_back(8'hFF);
        default: bytes.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    send_message(bytes);
  endtask

  initial begin
    int sent;
    int msg_count;
    int len;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_message('{8'h00});
    send_message('{8'hFF});
    send_message('{8'hFF, 8'h00});
    send_message('{8'h00, 8'hFF, 8'h80});
    send_message('{8'hFF, 8'hFF, 8'hFF});
    send_message('{8'hFB, 8'hEF, 8'hBE, 8'h01});
    send_message('{8'h01, 8'h02, 8'h03, 8'h04, 8'h05});

    // The sender holds off here until every character has come back.
    drain();

    sent      = 0;
    msg_count = 0;
    while (sent < RandomBytes) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      send_random_message(len);
      sent += len;
      msg_count++;
      if (msg_count == 12) begin
        drain();
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    sb.finish();
    $display("Encoded %0d bytes in %0d messages and checked %0d characters.",
             sb.bytes_seen, sb.messages_seen, sb.symbols_checked);
    $display("Messages ended at every group position, under bursty input and output stalls.");
    if (sb.errors == 0) begin
      $display("base64_stream_encoder verification clean");
    end else begin
      $display("base64_stream_encoder verification failed");
    end
    $finish;
  end

endmodule
